>>> hw/rtl/script_token_lexer_macros.svh
// Assertion macros for the script token lexer.
// Included by files that hold concurrent checks; depends on nothing else.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define STL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lexer check failed");

`else

`define STL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/stl_pkg.sv
// Shared types, character codes and helper functions for the script token lexer.
// Depends on nothing; every other RTL module file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // Counter widths of the line and column fields.
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_MARK = 2'd2;

    // Character codes the lexer recognizes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EOF    = 8'hFF;

    // One input word.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             char_value;
        logic                   quoted;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
        logic                   last;
    } t_out_word;

    // Everything one input word causes: one or two results.
    typedef struct packed {
        logic      two;
        t_out_word first;
        t_out_word second;
    } t_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_marker(input logic [7:0] b);
        return (b == CH_EQ) || (b == CH_LT) || (b == CH_GT) ||
               (b == CH_LBRACE) || (b == CH_RBRACE);
    endfunction

    function automatic logic is_line_end(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR) || (b == CH_EOF);
    endfunction

    function automatic logic is_delimiter(input logic [7:0] b);
        return is_blank(b) || is_marker(b) || (b == CH_HASH) ||
               (b == CH_QUOTE) || (b == CH_EOF);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stl_front.sv
// Front part of the lexer: accepts text words, runs the mode machine and
// counters, and pushes the results of each word into the queue. Uses stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire stl_pkg::t_in_word  i_word,
    input  wire stl_pkg::t_q_status i_q_status,
    output logic                    o_stall,
    output logic                    o_push,
    output stl_pkg::t_entry         o_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_QUOTED,
        MODE_UNQUOTED,
        MODE_COMMENT
    } t_mode;

    // Outcome of handling one byte from the idle mode.
    typedef struct packed {
        logic                            emit;
        logic [1:0]                      kind;
        t_mode                           mode;
        logic [stl_pkg::LINE_BITS-1:0]   line;
        logic [stl_pkg::COLUMN_BITS-1:0] col;
    } t_idle_res;

    t_mode                           r_mode, n_mode;
    logic [stl_pkg::LINE_BITS-1:0]   r_line, n_line;
    logic [stl_pkg::COLUMN_BITS-1:0] r_col, n_col;
    logic                            accept;
    logic                            have0, have1;
    stl_pkg::t_out_word              w0, w1;
    t_idle_res                       idl;
    logic [7:0]                      b;

    function automatic logic [stl_pkg::LINE_BITS-1:0] line_inc(
        input logic [stl_pkg::LINE_BITS-1:0] v
    );
        return (v == '1) ? v : v + stl_pkg::LINE_BITS'(1);
    endfunction

    function automatic logic [stl_pkg::COLUMN_BITS-1:0] col_inc(
        input logic [stl_pkg::COLUMN_BITS-1:0] v
    );
        return (v == '1) ? v : v + stl_pkg::COLUMN_BITS'(1);
    endfunction

    function automatic t_idle_res idle_step(
        input logic [7:0]                      ch,
        input logic [stl_pkg::LINE_BITS-1:0]   line,
        input logic [stl_pkg::COLUMN_BITS-1:0] col
    );
        t_idle_res res;
        res.emit = 1'b0;
        res.kind = stl_pkg::KIND_BYTE;
        res.mode = MODE_IDLE;
        res.line = line;
        res.col  = col_inc(col);
        if (ch == stl_pkg::CH_QUOTE) begin
            res.emit = 1'b1;
            res.mode = MODE_QUOTED;
        end else if (ch == stl_pkg::CH_HASH) begin
            res.mode = MODE_COMMENT;
        end else if (stl_pkg::is_marker(ch)) begin
            res.emit = 1'b1;
            res.kind = stl_pkg::KIND_MARK;
        end else if (stl_pkg::is_blank(ch)) begin
            if (ch == stl_pkg::CH_LF) begin
                res.line = line_inc(line);
                res.col  = '0;
            end
        end else begin
            res.emit = 1'b1;
            res.mode = MODE_UNQUOTED;
        end
        return res;
    endfunction

    assign b       = i_word.text_byte;
    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    // Mode machine and counters for one byte; up to two results.
    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_col  = r_col;
        have0  = 1'b0;
        have1  = 1'b0;
        idl    = idle_step(b, r_line, r_col);
        w0     = '{kind: stl_pkg::KIND_END, char_value: 8'h00, quoted: 1'b0,
                   line_number: r_line, column_number: r_col, last: 1'b0};
        w1     = '{kind: idl.kind, char_value: b, quoted: 1'b0,
                   line_number: idl.line, column_number: idl.col, last: 1'b1};
        if (i_word.end_of_input) begin
            // Flush a pending token, then clear everything.
            if ((r_mode == MODE_QUOTED) || (r_mode == MODE_UNQUOTED)) begin
                have0     = 1'b1;
                w0.quoted = (r_mode == MODE_QUOTED);
            end
            n_mode = MODE_IDLE;
            n_line = '0;
            n_col  = '0;
        end else begin
            unique case (r_mode)
                MODE_QUOTED: begin
                    if (b == stl_pkg::CH_QUOTE) begin
                        // Closing quote belongs to the token, then the token ends.
                        n_col            = col_inc(r_col);
                        n_mode           = MODE_IDLE;
                        have0            = 1'b1;
                        have1            = 1'b1;
                        w0.kind          = stl_pkg::KIND_BYTE;
                        w0.char_value    = b;
                        w0.column_number = n_col;
                        w1.kind          = stl_pkg::KIND_END;
                        w1.char_value    = 8'h00;
                        w1.quoted        = 1'b1;
                        w1.line_number   = r_line;
                        w1.column_number = n_col;
                    end else if (stl_pkg::is_line_end(b)) begin
                        // Token ends here and the byte is handled again from idle.
                        have0     = 1'b1;
                        w0.quoted = 1'b1;
                        have1     = idl.emit;
                        n_mode    = idl.mode;
                        n_line    = idl.line;
                        n_col     = idl.col;
                    end else begin
                        n_col            = col_inc(r_col);
                        have0            = 1'b1;
                        w0.kind          = stl_pkg::KIND_BYTE;
                        w0.char_value    = b;
                        w0.column_number = n_col;
                    end
                end
                MODE_UNQUOTED: begin
                    if (stl_pkg::is_delimiter(b)) begin
                        have0  = 1'b1;
                        have1  = idl.emit;
                        n_mode = idl.mode;
                        n_line = idl.line;
                        n_col  = idl.col;
                    end else begin
                        n_col            = col_inc(r_col);
                        have0            = 1'b1;
                        w0.kind          = stl_pkg::KIND_BYTE;
                        w0.char_value    = b;
                        w0.column_number = n_col;
                    end
                end
                MODE_COMMENT: begin
                    if (stl_pkg::is_line_end(b)) begin
                        n_mode = MODE_IDLE;
                    end
                    if (b == stl_pkg::CH_LF) begin
                        n_line = line_inc(r_line);
                        n_col  = '0;
                    end else begin
                        n_col = col_inc(r_col);
                    end
                end
                MODE_IDLE: begin
                    have0  = idl.emit;
                    w0     = w1;
                    n_mode = idl.mode;
                    n_line = idl.line;
                    n_col  = idl.col;
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
        w0.last = !have1;
        w1.last = 1'b1;
    end

    assign o_push         = accept && have0;
    assign o_entry.two    = have1;
    assign o_entry.first  = w0;
    assign o_entry.second = w1;

    // Lexer state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_line <= '0;
            r_col  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stl_queue.sv
// Short queue of result entries between the front and back parts of the lexer.
// Uses stl_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module stl_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire stl_pkg::t_entry    i_entry,
    input  wire logic               i_pop,
    output stl_pkg::t_q_status      o_status,
    output stl_pkg::t_entry         o_head
);

    stl_pkg::t_entry                r_mem [stl_pkg::QDEPTH];
    logic [stl_pkg::QPTR_BITS-1:0]  r_wp, r_rp;
    logic [stl_pkg::QCNT_BITS-1:0]  r_cnt;

    function automatic logic [stl_pkg::QPTR_BITS-1:0] ptr_next(
        input logic [stl_pkg::QPTR_BITS-1:0] p
    );
        return (p == stl_pkg::QPTR_BITS'(stl_pkg::QDEPTH - 1)) ?
               '0 : p + stl_pkg::QPTR_BITS'(1);
    endfunction

    assign o_status.full  = (r_cnt == stl_pkg::QCNT_BITS'(stl_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rp];

    // Entry storage; written only at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_next(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_next(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + stl_pkg::QCNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - stl_pkg::QCNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stl_back.sv
// Back part of the lexer: drains queue entries and delivers their results one
// word a cycle, unless stalled, through an output register. Uses stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire stl_pkg::t_q_status i_q_status,
    input  wire stl_pkg::t_entry    i_head,
    input  wire logic               i_stall,
    output logic                    o_pop,
    output logic                    o_valid,
    output stl_pkg::t_out_word      o_word
);

    logic               r_valid;
    logic               r_sel;
    stl_pkg::t_out_word r_word;
    logic               load;
    logic               entry_done;
    stl_pkg::t_out_word cur;

    // Pick the next result of the head entry.
    assign cur        = r_sel ? i_head.second : i_head.first;
    assign entry_done = r_sel || !i_head.two;
    assign load       = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_pop      = load && entry_done;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    // Output register valid and the result selector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !entry_done;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= cur;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/script_token_lexer.sv
// Top level of the script token lexer: front, queue and back parts with checks.
// Uses stl_pkg, stl_front, stl_queue, stl_back and script_token_lexer_macros.svh.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_word (text_byte, end_of_input)
//   result    out        o_valid / i_stall   o_word (kind .. last)
//
// The front takes one text word per cycle while the queue has room.
// A word causes zero, one or two results; the back delivers one result a cycle
// unless stalled, so the two results of a word leave the output register in turn.
// An accepted word's first result passes through the queue storage, then the output register.
// Reset clears the mode, counters, queue and output valid; no clearing pass.
// Either side may stall on its own; the four-entry queue absorbs the difference.
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_macros.svh"

module script_token_lexer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire stl_pkg::t_in_word  i_word,
    output logic                    o_stall,
    output logic                    o_valid,
    output stl_pkg::t_out_word      o_word,
    input  wire logic               i_stall
);

    logic               push;
    logic               pop;
    stl_pkg::t_entry    push_entry;
    stl_pkg::t_entry    head;
    stl_pkg::t_q_status q_status;

    // Front part: mode machine and counters.
    stl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_word     (i_word),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Queue between the two parts.
    stl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    // Back part: result delivery.
    stl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_word     (o_word)
    );

    // The queue is never pushed while full nor popped while empty.
    `STL_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, q_status.full, !push)
    `STL_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, q_status.empty, !pop)
    // Only a token end is quoted, and every other result is a byte or a marker.
    `STL_ASSERT_IMPLIES(a_end_fields, i_clk, i_rst_n,
        o_valid && (o_word.kind != stl_pkg::KIND_END),
        !o_word.quoted && ((o_word.kind == stl_pkg::KIND_BYTE) ||
        (o_word.kind == stl_pkg::KIND_MARK)))
    // A two-result entry is pushed with its first result not marked last.
    `STL_ASSERT_IMPLIES(a_entry_last, i_clk, i_rst_n, push,
        (push_entry.first.last == !push_entry.two) && push_entry.second.last)

endmodule

`default_nettype wire
